FILE: sv/efti_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
// Used by the front, queue, core, top level and checker; depends on nothing.
`default_nettype none

package efti_pkg;

  localparam int FRAC_BITS_DEF   = 28;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int PT_W        = 32;   // point and constant width
  localparam int RADIUS_W    = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int          LIMIT_RESET  = 255;
  localparam logic [30:0] RADIUS_RESET = 31'd536870912;  // 2.0 in Q4.28

  typedef enum logic [1:0] {
    VAR_MANDEL  = 2'd0,
    VAR_TRICORN = 2'd1,
    VAR_SHIP    = 2'd2,
    VAR_JULIA   = 2'd3
  } variant_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VARIANT  = 3'd0,
    REG_LIMIT    = 3'd1,
    REG_JULIA_RE = 3'd2,
    REG_JULIA_IM = 3'd3,
    REG_RADIUS   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL,
    ST_CHECK,
    ST_UPDATE,
    ST_DONE
  } core_state_e;

  // One queued item: start point, value added on each update, escape setup.
  typedef struct packed {
    logic signed [PT_W-1:0]  point_re;
    logic signed [PT_W-1:0]  point_im;
    logic signed [PT_W-1:0]  add_re;
    logic signed [PT_W-1:0]  add_im;
    logic [RADIUS_W-1:0]     radius;
    variant_e                variant;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/efti_front.sv
// Front end: configuration registers, item acceptance and classification.
// Builds a queue entry per accepted item; depends on efti_pkg.
`default_nettype none

module efti_front import efti_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [PT_W-1:0]   point_re_i,
  input  wire logic signed [PT_W-1:0]   point_im_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                     queue_full_i,
  output logic                          push_o,
  output entry_t                        entry_o,
  output logic [COUNT_WIDTH-1:0]        limit_o
);

  localparam logic [COUNT_WIDTH-1:0] LimitReset = COUNT_WIDTH'(LIMIT_RESET);

  variant_e                   variant_q;
  logic [COUNT_WIDTH-1:0]     limit_q;
  logic signed [PT_W-1:0]     jre_q;
  logic signed [PT_W-1:0]     jim_q;
  logic [RADIUS_W-1:0]        radius_q;
  logic                       julia;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_MANDEL;
      limit_q   <= LimitReset;
      jre_q     <= '0;
      jim_q     <= '0;
      radius_q  <= RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_VARIANT:  variant_q <= variant_e'(cfg_data_i[1:0]);
        REG_LIMIT:    limit_q   <= cfg_data_i[COUNT_WIDTH-1:0];
        REG_JULIA_RE: jre_q     <= cfg_data_i;
        REG_JULIA_IM: jim_q     <= cfg_data_i;
        REG_RADIUS:   radius_q  <= cfg_data_i[RADIUS_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  assign julia      = (variant_q == VAR_JULIA);
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;
  assign limit_o    = limit_q;

  // Julia adds the configured constant, every other variant adds the point.
  always_comb begin
    entry_o.point_re = point_re_i;
    entry_o.point_im = point_im_i;
    entry_o.add_re   = julia ? jre_q : point_re_i;
    entry_o.add_im   = julia ? jim_q : point_im_i;
    entry_o.radius   = radius_q;
    entry_o.variant  = variant_q;
  end

endmodule

`default_nettype wire

FILE: sv/efti_queue.sv
// Short queue of classified items between front end and iteration core.
// Register array with read and write pointers; depends on efti_pkg.
`default_nettype none

module efti_queue import efti_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  entry_t      push_data_i,
  input  wire logic   pop_i,
  output entry_t      pop_data_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastP  = PtrW'(QUEUE_DEPTH - 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_q, wr_d;
  logic [PtrW-1:0]    rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == DepthC);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastP) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastP) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/efti_core.sv
// Iteration core: runs z = f(z) + a per item with half-width partial products,
// tests the escape bound and holds the result register. Depends on efti_pkg.
`default_nettype none

module efti_core import efti_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     empty_i,
  input  entry_t                        entry_i,
  output logic                          pop_o,
  input  wire logic [COUNT_WIDTH-1:0]   limit_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [COUNT_WIDTH-1:0]        iteration_count_o
);

  // z stays below max(R^2, 4) plus the addend after any update that passed.
  localparam int ZT1  = 62 - FRAC_BITS;
  localparam int ZT2  = FRAC_BITS + 2;
  localparam int ZT12 = (ZT1 > ZT2) ? ZT1 : ZT2;
  localparam int ZMAX = (ZT12 > 31) ? ZT12 : 31;
  localparam int ZW   = ZMAX + 2;       // signed z width
  localparam int M    = ZW - 1;         // magnitude width
  localparam int H    = (M + 1) / 2;    // half-operand width
  localparam int PRW  = 2 * H;          // partial product width
  localparam int PW   = 2 * M;          // full product width
  localparam int MW   = PW + 1;         // sum / difference width
  localparam logic [2:0] PH_LAST = 3'd4;
  localparam logic [2:0] PH_ACC0 = 3'd1;
  localparam logic [MW-1:0] BOUND_FOUR = MW'(1) << (2 * FRAC_BITS + 2);

  core_state_e              state_q, state_d;
  logic signed [ZW-1:0]     x_q, x_d, y_q, y_d;
  logic signed [PT_W-1:0]   are_q, are_d, aim_q, aim_d;
  variant_e                 var_q, var_d;
  logic [MW-1:0]            bound_q, bound_d;
  logic [COUNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic [M-1:0]             ax_q, ax_d, ay_q, ay_d;
  logic                     sx_q, sx_d, sy_q, sy_d;
  logic [2:0]               ph_q, ph_d;
  logic [PRW-1:0]           pxx_q, pxx_d, pyy_q, pyy_d, pxy_q, pxy_d;
  logic [PW-1:0]            axx_q, axx_d, ayy_q, ayy_d, axy_q, axy_d;
  logic signed [MW-1:0]     diff_q, diff_d, sxy_q, sxy_d;
  logic                     out_valid_q;
  logic [COUNT_WIDTH-1:0]   out_count_q;

  logic                     out_free, out_load, julia, in_bound, neg_xy;
  logic [61:0]              rsq;
  logic signed [ZW-1:0]     x_neg, y_neg, are_ext, aim_ext;
  logic [H-1:0]             ax_lo, ax_hi, ay_lo, ay_hi, op_x, op_y;
  logic [PW-1:0]            ext_xx, ext_yy, ext_xy;
  logic [MW-1:0]            mag, xy_ext;
  logic signed [MW-1:0]     x_sh, y_sh;
  logic [COUNT_WIDTH-1:0]   cnt_inc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign julia    = (var_q == VAR_JULIA);
  assign rsq      = 62'(entry_i.radius) * 62'(entry_i.radius);
  assign x_neg    = -x_q;
  assign y_neg    = -y_q;
  assign are_ext  = {{(ZW-PT_W){are_q[PT_W-1]}}, are_q};
  assign aim_ext  = {{(ZW-PT_W){aim_q[PT_W-1]}}, aim_q};

  // Phase p multiplies halves: bit 1 picks the high half of x, bit 0 of y.
  assign ax_lo = ax_q[H-1:0];
  assign ax_hi = H'(ax_q >> H);
  assign ay_lo = ay_q[H-1:0];
  assign ay_hi = H'(ay_q >> H);

  // Partial product of the previous phase, shifted to its weight.
  always_comb begin
    ext_xx = PW'(pxx_q);
    ext_yy = PW'(pyy_q);
    ext_xy = PW'(pxy_q);
    if (ph_q == PH_LAST) begin
      ext_xx = ext_xx << (2 * H);
      ext_yy = ext_yy << (2 * H);
      ext_xy = ext_xy << (2 * H);
    end else if (ph_q != PH_ACC0) begin
      ext_xx = ext_xx << H;
      ext_yy = ext_yy << H;
      ext_xy = ext_xy << H;
    end
  end

  assign mag      = MW'(axx_q) + MW'(ayy_q);
  assign in_bound = julia ? (mag < bound_q) : (mag <= bound_q);
  assign xy_ext   = MW'(axy_q);
  assign neg_xy   = (var_q != VAR_SHIP) && ((sx_q ^ sy_q) ^ (var_q == VAR_TRICORN));
  assign x_sh     = diff_q >>> FRAC_BITS;
  assign y_sh     = sxy_q >>> (FRAC_BITS - 1);
  assign cnt_inc  = cnt_q + 1'b1;

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    are_d   = are_q;
    aim_d   = aim_q;
    var_d   = var_q;
    bound_d = bound_q;
    cnt_d   = cnt_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    ph_d    = ph_q;
    pxx_d   = pxx_q;
    pyy_d   = pyy_q;
    pxy_d   = pxy_q;
    axx_d   = axx_q;
    ayy_d   = ayy_q;
    axy_d   = axy_q;
    diff_d  = diff_q;
    sxy_d   = sxy_q;
    pop_o   = 1'b0;
    op_x    = ph_q[1] ? ax_hi : ax_lo;
    op_y    = ph_q[0] ? ay_hi : ay_lo;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          x_d     = {{(ZW-PT_W){entry_i.point_re[PT_W-1]}}, entry_i.point_re};
          y_d     = {{(ZW-PT_W){entry_i.point_im[PT_W-1]}}, entry_i.point_im};
          are_d   = entry_i.add_re;
          aim_d   = entry_i.add_im;
          var_d   = entry_i.variant;
          bound_d = (entry_i.variant == VAR_JULIA) ? MW'(rsq) : BOUND_FOUR;
          cnt_d   = '0;
          state_d = (limit_i == '0) ? ST_DONE : ST_ABS;
        end
      end
      ST_ABS: begin
        sx_d    = x_q[ZW-1];
        sy_d    = y_q[ZW-1];
        ax_d    = x_q[ZW-1] ? x_neg[M-1:0] : x_q[M-1:0];
        ay_d    = y_q[ZW-1] ? y_neg[M-1:0] : y_q[M-1:0];
        axx_d   = '0;
        ayy_d   = '0;
        axy_d   = '0;
        ph_d    = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // Form one partial product per lane, add the previous one in.
        if (ph_q != PH_LAST) begin
          pxx_d = PRW'(ph_q[1] ? ax_hi : ax_lo) * PRW'(ph_q[0] ? ax_hi : ax_lo);
          pyy_d = PRW'(ph_q[1] ? ay_hi : ay_lo) * PRW'(ph_q[0] ? ay_hi : ay_lo);
          pxy_d = PRW'(op_x) * PRW'(op_y);
        end
        if (ph_q != '0) begin
          axx_d = axx_q + ext_xx;
          ayy_d = ayy_q + ext_yy;
          axy_d = axy_q + ext_xy;
        end
        ph_d    = ph_q + 1'b1;
        if (ph_q == PH_LAST) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        diff_d  = $signed(MW'(axx_q)) - $signed(MW'(ayy_q));
        sxy_d   = neg_xy ? -$signed(xy_ext) : $signed(xy_ext);
        state_d = in_bound ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        x_d     = x_sh[ZW-1:0] + are_ext;
        y_d     = y_sh[ZW-1:0] + aim_ext;
        cnt_d   = cnt_inc;
        state_d = (cnt_inc == limit_i) ? ST_DONE : ST_ABS;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    are_q  <= are_d;
    aim_q  <= aim_d;
    var_q  <= var_d;
    bound_q <= bound_d;
    cnt_q  <= cnt_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    ph_q   <= ph_d;
    pxx_q  <= pxx_d;
    pyy_q  <= pyy_d;
    pxy_q  <= pxy_d;
    axx_q  <= axx_d;
    ayy_q  <= ayy_d;
    axy_q  <= axy_d;
    diff_q <= diff_d;
    sxy_q  <= sxy_d;
  end

  // Result register: load on finish, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= cnt_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = out_count_q;

endmodule

`default_nettype wire

FILE: sv/escape_time_fractal_iterator.sv
// Escape-time fractal iterator (mandelbrot, tricorn, burning ship, julia).
// Input channel: in_valid_i / in_stall_o with point_re_i, point_im_i in Q4.28.
// Output channel: out_valid_o / out_stall_i with iteration_count_o.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i picks
// variant, iteration_limit, julia_const_re, julia_const_im, escape_radius.
// Write configuration only while no item is in flight.
// A front end takes items into a two-entry queue; the core pops one at a time.
// Each iteration steps the core through absolute values, four half-width
// partial products per square and cross product plus an accumulate step,
// the escape test, then the update; the partial-product lanes are shared
// across the phases.
// The result register frees the core, which pulls the next item while a
// result waits; a stalled result holds its value until taken.
// Reset clears the queue, core and result register, and restores the reset
// configuration: mandelbrot, limit 255, julia constant 0, radius 2.0.
`default_nettype none

module escape_time_fractal_iterator import efti_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [PT_W-1:0]   point_re_i,
  input  wire logic signed [PT_W-1:0]   point_im_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [COUNT_WIDTH-1:0]        iteration_count_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i
);

  entry_t                   push_entry, pop_entry;
  logic                     push, pop, full, empty;
  logic [COUNT_WIDTH-1:0]   limit;

  efti_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_re_i   (point_re_i),
    .point_im_i   (point_im_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (full),
    .push_o       (push),
    .entry_o      (push_entry),
    .limit_o      (limit)
  );

  efti_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .full_o      (full),
    .empty_o     (empty)
  );

  efti_core #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .entry_i           (pop_entry),
    .pop_o             (pop),
    .limit_i           (limit),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .iteration_count_o (iteration_count_o)
  );

endmodule

`default_nettype wire

FILE: sv/efti_checker.sv
// Port-level checker for the escape-time fractal iterator, bound to the top.
// Tracks items in flight and the written limit; depends on efti_pkg.
`default_nettype none

module efti_checker import efti_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_stall_o,
  input  wire logic signed [PT_W-1:0]   point_re_i,
  input  wire logic signed [PT_W-1:0]   point_im_i,
  input  wire logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  input  wire logic [COUNT_WIDTH-1:0]   iteration_count_o,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i
);

  // queue entries, one item in the core, one in the result register
  localparam int CAPACITY = QUEUE_DEPTH + 2;
  localparam int PendW    = $clog2(CAPACITY + 1);
  localparam logic [PendW-1:0] CapC = PendW'(CAPACITY);

  logic [PendW-1:0]         pending_q;
  logic [COUNT_WIDTH-1:0]   limit_q;
  logic                     in_acc, out_acc;
  logic                     unused_pt;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign unused_pt = ^{point_re_i, point_im_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= COUNT_WIDTH'(LIMIT_RESET);
    end else if (cfg_valid_i && cfg_ready_o && (cfg_reg_e'(cfg_index_i) == REG_LIMIT)) begin
      limit_q <= cfg_data_i[COUNT_WIDTH-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(iteration_count_o)))
    else $error("stalled result changed or dropped");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (iteration_count_o <= limit_q))
    else $error("iteration count above limit");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni || unused_pt === 1'bx)
    out_valid_o |-> (pending_q != '0))
    else $error("result without an accepted item");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CapC)
    else $error("more items in flight than storage");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == CapC) |-> in_stall_o)
    else $error("item accepted with all storage taken");

endmodule

bind escape_time_fractal_iterator efti_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_efti_checker (.*);

`default_nettype wire
